// ===== sv/mdsc_pkg.sv =====
package mdsc_pkg;

	// Field and register widths
	localparam int CODE_W     = 8;
	localparam int VALUE_W    = 16;
	localparam int POS_W      = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_DIGITS = 3;

	// Request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_MASK     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BASE     = 8'd3;

	// Register reset values
	localparam logic [2:0]         RST_POINT_MASK     = 3'd0;
	localparam logic               RST_BLINK_ENABLE   = 1'b0;
	localparam logic [VALUE_W-1:0] RST_BLINK_INTERVAL = 16'd500;
	localparam logic [VALUE_W-1:0] RST_ERROR_BASE     = 16'd1000;

	// Digit positions
	localparam logic [POS_W-1:0] POS_UNITS    = 2'd0;
	localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
	localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd2;
	localparam logic [POS_W-1:0] POS_UNUSED   = 2'd3;

	// Three display codes produced by a load
	typedef struct packed {
		logic [CODE_W-1:0] hundreds;
		logic [CODE_W-1:0] tens;
		logic [CODE_W-1:0] units;
	} digits_t;

endpackage

// ===== sv/mdsc_if.sv =====
// Input word channel: load or scan tick
interface mdsc_item_if;
	import mdsc_pkg::*;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [VALUE_W-1:0] display_value;

	modport source (output valid, output req_type, output display_value, input ready);
	modport sink   (input valid, input req_type, input display_value, output ready);
endinterface

// Result word channel: one digit drive
interface mdsc_result_if;
	import mdsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  digit_position;
	logic [CODE_W-1:0] digit_code;
	logic              point_on;

	modport source (output valid, output digit_position, output digit_code,
		output point_on, input ready);
	modport sink   (input valid, input digit_position, input digit_code,
		input point_on, output ready);
endinterface

// Register write channel
interface mdsc_cfg_if;
	import mdsc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/multiplexed_three_digit_display_scan_top.sv =====
// Three-digit multiplexed display scan driver.
// A tick word passes the input register, then the result register;
// loads produce no result.
// Throughput: one word per cycle; a tick at the input register waits on a held result.
// Reset: asynchronous, active low; clears pipeline valids, scan and blink state,
// stored digits to zero and registers to their reset values.
module multiplexed_three_digit_display_scan_top
	import mdsc_pkg::*;
#(
	parameter int TABLE_SIZE    = 16,
	parameter int BLANK_CODE    = 15,
	parameter int LETTER_E_CODE = 14
) (
	input logic         clk,
	input logic         arst_n,
	mdsc_item_if.sink   item,
	mdsc_result_if.source result,
	mdsc_cfg_if.sink    cfg
);

	// Configuration registers
	logic [2:0]         point_mask_q;
	logic               blink_en_q;
	logic [VALUE_W-1:0] blink_int_q;
	logic [VALUE_W-1:0] err_base_q;

	// Input stage
	logic               valid_s1;
	logic               req_s1;
	logic [VALUE_W-1:0] value_s1;

	// Display state
	logic [CODE_W-1:0]  digit_q [NUM_DIGITS];
	logic [POS_W-1:0]   scan_pos_q;
	logic [VALUE_W-1:0] blink_cnt_q;
	logic               blink_fall_q;

	// Result register
	logic               res_valid_q;
	logic [POS_W-1:0]   res_pos_q;
	logic [CODE_W-1:0]  res_code_q;
	logic               res_point_q;

	logic               out_free;
	logic               adv;
	logic               tick_adv;
	digits_t            split_digits;
	logic               blank;
	logic [VALUE_W-1:0] blink_cnt_nx;
	logic               blink_fall_nx;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   pos_nx;
	logic [CODE_W-1:0]  code;
	logic               point;

	// Handshake
	assign out_free   = !res_valid_q || result.ready;
	assign adv        = valid_s1 && ((req_s1 == REQ_LOAD) || out_free);
	assign tick_adv   = adv && (req_s1 == REQ_TICK);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_mask_q <= RST_POINT_MASK;
			blink_en_q   <= RST_BLINK_ENABLE;
			blink_int_q  <= RST_BLINK_INTERVAL;
			err_base_q   <= RST_ERROR_BASE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_POINT_MASK:     point_mask_q <= cfg.data[2:0];
				CFG_BLINK_ENABLE:   blink_en_q   <= cfg.data[0];
				CFG_BLINK_INTERVAL: blink_int_q  <= cfg.data;
				CFG_ERROR_BASE:     err_base_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_s1   <= item.req_type;
			value_s1 <= item.display_value;
		end
	end

	mdsc_split #(
		.BLANK_CODE    (BLANK_CODE),
		.LETTER_E_CODE (LETTER_E_CODE)
	) u_split (
		.value      (value_s1),
		.error_base (err_base_q),
		.digits     (split_digits)
	);

	// Blink counter: up to the interval, then down to zero while blanked
	always_comb begin
		blank         = 1'b0;
		blink_cnt_nx  = blink_cnt_q;
		blink_fall_nx = blink_fall_q;
		if (blink_en_q) begin
			if (!blink_fall_q) begin
				if (blink_cnt_q < blink_int_q) begin
					blink_cnt_nx = blink_cnt_q + 16'd1;
				end else begin
					blink_fall_nx = 1'b1;
					blank         = 1'b1;
				end
			end else if (blink_cnt_q != '0) begin
				blink_cnt_nx = blink_cnt_q - 16'd1;
				blank        = 1'b1;
			end else begin
				blink_fall_nx = 1'b0;
			end
		end
	end

	// Digit selection for the current scan position
	always_comb begin
		pos    = (scan_pos_q == POS_UNUSED) ? POS_UNITS : scan_pos_q;
		pos_nx = (pos == POS_HUNDREDS) ? POS_UNITS : pos + 2'd1;
		code   = blank ? CODE_W'(BLANK_CODE) : digit_q[pos];
		point  = point_mask_q[pos];
		// codes past the segment table drive blank with the point off
		if ({1'b0, code} >= 9'(TABLE_SIZE)) begin
			code  = CODE_W'(BLANK_CODE);
			point = 1'b0;
		end
	end

	// Display state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) digit_q[i] <= '0;
			scan_pos_q   <= POS_UNITS;
			blink_cnt_q  <= '0;
			blink_fall_q <= 1'b0;
		end else if (adv) begin
			if (req_s1 == REQ_LOAD) begin
				digit_q[0] <= split_digits.units;
				digit_q[1] <= split_digits.tens;
				digit_q[2] <= split_digits.hundreds;
			end else begin
				scan_pos_q   <= pos_nx;
				blink_cnt_q  <= blink_cnt_nx;
				blink_fall_q <= blink_fall_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_adv) begin
			res_pos_q   <= pos;
			res_code_q  <= code;
			res_point_q <= point;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.digit_position = res_pos_q;
	assign result.digit_code     = res_code_q;
	assign result.point_on       = res_point_q;

endmodule

// ===== sv/mdsc_split.sv =====
// Splits a load value into hundreds/tens/units, or into the error pattern
module mdsc_split
	import mdsc_pkg::*;
#(
	parameter int BLANK_CODE    = 15,
	parameter int LETTER_E_CODE = 14
) (
	input  logic [VALUE_W-1:0] value,
	input  logic [VALUE_W-1:0] error_base,
	output digits_t            digits
);

	// floor(2^19 / 100); estimate is low by at most one
	localparam logic [12:0] RECIP_100 = 13'd5242;

	logic [28:0]        prod;
	logic [9:0]         q_est;
	logic [16:0]        q_x100;
	logic [16:0]        rem_est;
	logic [9:0]         q_hund;
	logic [7:0]         rem;
	logic [3:0]         q_tens;
	logic [7:0]         tens_x10;
	logic [7:0]         q_units;
	logic [VALUE_W-1:0] err_num;

	// Hundreds by reciprocal multiply, one correction step
	always_comb begin
		prod    = 29'(value) * 29'(RECIP_100);
		q_est   = prod[28:19];
		q_x100  = (17'(q_est) << 6) + (17'(q_est) << 5) + (17'(q_est) << 2);
		rem_est = {1'b0, value} - q_x100;
		if (rem_est >= 17'd100) begin
			q_hund = q_est + 10'd1;
			rem    = 8'(rem_est - 17'd100);
		end else begin
			q_hund = q_est;
			rem    = rem_est[7:0];
		end
	end

	// Tens and units of a remainder below 100
	always_comb begin
		q_tens = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem >= 8'(10 * k)) q_tens = 4'(k);
		end
		tens_x10 = (8'(q_tens) << 3) + (8'(q_tens) << 1);
		q_units  = rem - tens_x10;
	end

	assign err_num = value - error_base;

	always_comb begin
		if (value < error_base) begin
			digits.hundreds = q_hund[CODE_W-1:0];
			digits.tens     = 8'(q_tens);
			digits.units    = q_units;
		end else begin
			digits.hundreds = CODE_W'(LETTER_E_CODE);
			digits.tens     = err_num[CODE_W-1:0];
			digits.units    = CODE_W'(BLANK_CODE);
		end
	end

endmodule

// ===== sv/mdsc_checker.sv =====
// Port-level checks on the result channel
module mdsc_checker
	import mdsc_pkg::*;
#(
	parameter int TABLE_SIZE = 16,
	parameter int BLANK_CODE = 15
) (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [POS_W-1:0]  res_pos,
	input logic [CODE_W-1:0] res_code,
	input logic              res_point
);

	// stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({res_pos, res_code, res_point}))
		else $error("result word changed while stalled");

	// scan never drives the unused position
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_pos != POS_UNUSED)
		else $error("unused digit position driven");

	// every driven code is in the segment table or is blank
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_code} < 9'(TABLE_SIZE)) || (res_code == CODE_W'(BLANK_CODE)))
		else $error("digit code outside segment table");

	// no result word while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind multiplexed_three_digit_display_scan_top mdsc_checker #(
	.TABLE_SIZE (TABLE_SIZE),
	.BLANK_CODE (BLANK_CODE)
) u_mdsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_pos   (result.digit_position),
	.res_code  (result.digit_code),
	.res_point (result.point_on)
);

// ===== tb/mdsc_scan_checker.sv =====
// Watches the item, result and register channels of the display scan block,
// predicts each digit drive and compares it with what comes out.
module mdsc_scan_checker
	import mdsc_pkg::*;
#(
	parameter int TABLE_SIZE    = 16,
	parameter int BLANK_CODE    = 15,
	parameter int LETTER_E_CODE = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  logic                  item_req_type,
	input  logic [VALUE_W-1:0]    item_display_value,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [POS_W-1:0]      result_digit_position,
	input  logic [CODE_W-1:0]     result_digit_code,
	input  logic                  result_point_on,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending_count
);

	typedef struct {
		logic [POS_W-1:0]  pos;
		logic [CODE_W-1:0] code;
		logic              point;
	} digit_drive_t;

	// Register copies
	logic [2:0]         point_mask;
	logic               blink_on;
	logic [VALUE_W-1:0] blink_period;
	logic [VALUE_W-1:0] err_base;

	// Display state
	logic [CODE_W-1:0]  shown_digits [NUM_DIGITS];
	logic [POS_W-1:0]   scan_pos;
	logic [VALUE_W-1:0] blink_cnt;
	logic               blink_down;

	digit_drive_t digit_drives_due[$];

	initial begin
		fail_count    = 0;
		pending_count = 0;
	end

	// Up/down blink counter; returns 1 while the display is blanked
	function automatic logic blink_advance();
		if (!blink_down) begin
			if (blink_cnt < blink_period) begin
				blink_cnt = blink_cnt + 1'b1;
				return 1'b0;
			end
			blink_down = 1'b1;
			return 1'b1;
		end
		if (blink_cnt != '0) begin
			blink_cnt = blink_cnt - 1'b1;
			return 1'b1;
		end
		blink_down = 1'b0;
		return 1'b0;
	endfunction

	// Decimal split, or letter E with wrapped error number
	function automatic void store_value(logic [VALUE_W-1:0] v);
		if (v < err_base) begin
			shown_digits[POS_HUNDREDS] = CODE_W'(v / 100);
			shown_digits[POS_TENS]     = CODE_W'((v % 100) / 10);
			shown_digits[POS_UNITS]    = CODE_W'(v % 10);
		end else begin
			shown_digits[POS_HUNDREDS] = CODE_W'(LETTER_E_CODE);
			shown_digits[POS_TENS]     = CODE_W'(v - err_base);
			shown_digits[POS_UNITS]    = CODE_W'(BLANK_CODE);
		end
	endfunction

	// One scan tick: next position, its code and decimal point
	function automatic digit_drive_t scan_tick();
		digit_drive_t     d;
		logic             blanked;
		logic [POS_W-1:0] p;
		blanked = 1'b0;
		if (blink_on)
			blanked = blink_advance();
		p = (scan_pos > POS_HUNDREDS) ? POS_UNITS : scan_pos;
		d.pos   = p;
		d.code  = blanked ? CODE_W'(BLANK_CODE) : shown_digits[p];
		d.point = point_mask[p];
		// codes past the segment table go dark, point included
		if (int'(d.code) >= TABLE_SIZE) begin
			d.code  = CODE_W'(BLANK_CODE);
			d.point = 1'b0;
		end
		scan_pos = (p == POS_HUNDREDS) ? POS_UNITS : p + 1'b1;
		return d;
	endfunction

	task automatic check_drive();
		digit_drive_t d;
		if (digit_drives_due.size() == 0) begin
			$error("unexpected digit word: pos %0d code %0d point %0d",
				result_digit_position, result_digit_code, result_point_on);
			fail_count++;
		end else begin
			d = digit_drives_due.pop_front();
			if (result_digit_position !== d.pos) begin
				$error("digit_position: expected %0d, got %0d", d.pos,
					result_digit_position);
				fail_count++;
			end
			if (result_digit_code !== d.code) begin
				$error("digit_code: expected %0d, got %0d", d.code, result_digit_code);
				fail_count++;
			end
			if (result_point_on !== d.point) begin
				$error("point_on: expected %0d, got %0d", d.point, result_point_on);
				fail_count++;
			end
		end
	endtask

	// Result check first: a word accepted at this edge cannot be its source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_mask   = RST_POINT_MASK;
			blink_on     = RST_BLINK_ENABLE;
			blink_period = RST_BLINK_INTERVAL;
			err_base     = RST_ERROR_BASE;
			foreach (shown_digits[i])
				shown_digits[i] = '0;
			scan_pos   = POS_UNITS;
			blink_cnt  = '0;
			blink_down = 1'b0;
			digit_drives_due.delete();
		end else begin
			if (result_valid && result_ready)
				check_drive();
			if (item_valid && item_ready) begin
				if (item_req_type == REQ_LOAD)
					store_value(item_display_value);
				else
					digit_drives_due.push_back(scan_tick());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POINT_MASK:     point_mask   = cfg_data[2:0];
					CFG_BLINK_ENABLE:   blink_on     = cfg_data[0];
					CFG_BLINK_INTERVAL: blink_period = cfg_data[VALUE_W-1:0];
					CFG_ERROR_BASE:     err_base     = cfg_data[VALUE_W-1:0];
					default: ;
				endcase
			end
		end
		pending_count = digit_drives_due.size();
	end

endmodule

// ===== tb/tb_multiplexed_three_digit_display_scan_top.sv =====
module tb_multiplexed_three_digit_display_scan_top;
	import mdsc_pkg::*;

	// Index that maps to no register; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'hFF;

	logic clk;
	logic arst_n;

	mdsc_item_if   item_ch ();
	mdsc_result_if result_ch ();
	mdsc_cfg_if    cfg_ch ();

	int fail_count;
	int pending_count;

	int                 send_idle_pct;
	int                 recv_stall_pct;
	bit                 long_hold;
	logic [VALUE_W-1:0] cur_err_base;

	multiplexed_three_digit_display_scan_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	mdsc_scan_checker u_checker (
		.clk                   (clk),
		.arst_n                (arst_n),
		.item_valid            (item_ch.valid),
		.item_ready            (item_ch.ready),
		.item_req_type         (item_ch.req_type),
		.item_display_value    (item_ch.display_value),
		.result_valid          (result_ch.valid),
		.result_ready          (result_ch.ready),
		.result_digit_position (result_ch.digit_position),
		.result_digit_code     (result_ch.digit_code),
		.result_point_on       (result_ch.point_on),
		.cfg_valid             (cfg_ch.valid),
		.cfg_ready             (cfg_ch.ready),
		.cfg_index             (cfg_ch.index),
		.cfg_data              (cfg_ch.data),
		.fail_count            (fail_count),
		.pending_count         (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// Result side: random stalls, or one long hold-off when asked
	initial begin
		bit hold_done;
		hold_done       = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				result_ch.ready = 1'b0;
				repeat (60) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Entered and left at a falling edge
	task automatic offer_word(logic req, logic [VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid         = 1'b1;
		item_ch.req_type      = req;
		item_ch.display_value = val;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Drain outstanding digit words, then let trailing loads clear the pipe
	task automatic settle();
		item_ch.valid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_regs(logic [2:0] pm, logic be, logic [VALUE_W-1:0] bi,
		logic [VALUE_W-1:0] eb);
		settle();
		write_reg(CFG_POINT_MASK, CFG_DATA_W'(pm));
		write_reg(CFG_BLINK_ENABLE, CFG_DATA_W'(be));
		write_reg(CFG_BLINK_INTERVAL, bi);
		write_reg(CFG_ERROR_BASE, eb);
		cur_err_base = eb;
	endtask

	task automatic load_and_scan(logic [VALUE_W-1:0] val);
		offer_word(REQ_LOAD, val);
		repeat (NUM_DIGITS) offer_word(REQ_TICK, '0);
	endtask

	// Mostly ticks; loads aimed below, at and past the error base
	task automatic random_words(int n, bit with_hold);
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 8)
				long_hold = 1'b1;
			if ($urandom_range(99) < 70) begin
				offer_word(REQ_TICK, VALUE_W'($urandom));
			end else begin
				case ($urandom_range(3))
					0: v = VALUE_W'($urandom);
					1: v = (cur_err_base == 0) ? VALUE_W'($urandom)
						: VALUE_W'($urandom_range(int'(cur_err_base) - 1));
					2: v = cur_err_base + VALUE_W'($urandom_range(300));
					default: v = VALUE_W'($urandom_range(999));
				endcase
				offer_word(REQ_LOAD, v);
			end
		end
	endtask

	task automatic run_phase(logic [2:0] pm, logic be, logic [VALUE_W-1:0] bi,
		logic [VALUE_W-1:0] eb, int n, int idle_pct, int stall_pct, bit with_hold);
		set_regs(pm, be, bi, eb);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		random_words(n, with_hold);
	endtask

	initial begin
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.req_type      = REQ_LOAD;
		item_ch.display_value = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = '0;
		cfg_ch.data           = '0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		long_hold             = 1'b0;
		cur_err_base          = RST_ERROR_BASE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset state, split extremes, error codes, wrap past table
		offer_word(REQ_TICK, '0);
		set_regs(3'd5, 1'b0, 16'd500, 16'd1000);
		load_and_scan(16'd999);
		load_and_scan(16'd1000);
		load_and_scan(16'd1999);
		load_and_scan(16'hFFFF);
		set_regs(3'd5, 1'b0, 16'd500, 16'hFFFF);
		load_and_scan(16'd65534);

		// Random phases across idle patterns and register settings
		run_phase(3'd7, 1'b1, 16'd3, 16'd1000, 70, 0, 0, 1'b0);
		run_phase(3'd2, 1'b1, 16'd0, 16'd0, 60, 64, 0, 1'b0);
		run_phase(3'($urandom_range(7)), 1'b0, 16'hFFFF, 16'hFFFF, 60, 0, 64, 1'b0);
		run_phase(3'd0, 1'b1, 16'd1, 16'd300, 60, 0, 0, 1'b1);
		run_phase(3'd6, 1'b1, 16'hFFFF, VALUE_W'($urandom), 60, 33, 33, 1'b0);
		run_phase(3'd4, 1'b1, 16'd7, 16'd2000, 70, 0, 64, 1'b0);
		settle();
		write_reg(CFG_NO_REG, 16'hFFFF);
		run_phase(3'd1, 1'b0, 16'd0, 16'd1600, 70, 33, 33, 1'b0);

		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mdsc_pkg.sv
sv/mdsc_if.sv
sv/mdsc_split.sv
sv/multiplexed_three_digit_display_scan_top.sv
sv/mdsc_checker.sv
tb/mdsc_scan_checker.sv
tb/tb_multiplexed_three_digit_display_scan_top.sv
